// ----- rtl/core/bcse_pkg.sv -----
// Shared types, codes and constants of the battery charge state estimator.
package bcse_pkg;

  // Field widths
  localparam int PCT_W  = 7;
  localparam int MV_W   = 16;
  localparam int WORD_W = 32;
  localparam int GAP_W  = 16;

  // Bit-serial multiplier: 32-bit multiplicand, 16-bit multiplier
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // Bit-serial restoring divider: 40-bit dividend, 32-bit divisor
  localparam int DIV_W     = 40;
  localparam int DSR_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // floor(x / 10) = (x * 52429) >> 19 for any 16-bit x
  localparam logic [MUL_A_W-1:0] RECIP_TEN   = 32'd52429;
  localparam int                 RECIP_SHIFT = 19;

  localparam logic [DSR_W-1:0]  MS_PER_S = 32'd1000;
  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;

  localparam logic [WORD_W-1:0] FULL_CHARGE_RESET = 32'd100000000;
  localparam logic [GAP_W-1:0]  MAX_GAP_RESET     = 16'd2000;

  // Operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_INIT   = 2'd1,
    OP_DEINIT = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FULL_CHARGE = 1'b0,
    REG_MAX_GAP     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [MV_W-1:0]   battery_mv;
    logic [MV_W-1:0]   system_ma;
    logic              charger_present;
    logic [MV_W-1:0]   elapsed_ms;
    logic [PCT_W-1:0]  ocv_percent;
    logic [WORD_W-1:0] seed_mws;
  } item_t;

  typedef struct packed {
    logic [PCT_W-1:0] battery_level;
    logic [PCT_W-1:0] voltage_percent;
    logic [PCT_W-1:0] charge_percent;
    logic [MV_W-1:0]  open_circuit_mv;
    logic             skipped;
  } result_t;

  typedef struct packed {
    cfg_reg_t          index;
    logic [WORD_W-1:0] value;
  } cfg_t;

  // Status of a serial unit towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_OCV_MUL,
    S_C1_MUL,
    S_C1_DIV,
    S_C2_MUL,
    S_C2_DIV,
    S_PCT_CHK,
    S_PCT_MUL,
    S_PCT_DIV,
    S_AVG_CHK,
    S_AVG_DIV,
    S_LEVEL,
    S_SEED_DIV,
    S_SEED_MUL,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/bcse_if.sv -----
// Handshake channels of the estimator: input items, results and configuration writes.
interface bcse_item_if;
  logic             valid;
  logic             ready;
  bcse_pkg::item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bcse_result_if;
  logic              valid;
  logic              ready;
  bcse_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bcse_cfg_if;
  logic           valid;
  logic           ready;
  bcse_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/bcse_mul.sv -----
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module bcse_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bcse_pkg::MUL_A_W-1:0]  a,
  input  logic [bcse_pkg::MUL_B_W-1:0]  b,
  output logic [bcse_pkg::MUL_P_W-1:0]  product,
  output bcse_pkg::unit_stat_t          stat
);

  logic [bcse_pkg::MUL_A_W-1:0]   a_q;
  logic [bcse_pkg::MUL_B_W-1:0]   b_q;
  logic [bcse_pkg::MUL_CNT_W-1:0] steps;
  logic [bcse_pkg::MUL_A_W:0]     part;

  // Add the multiplicand into the upper half when the current bit is set
  assign part = {1'b0, product[bcse_pkg::MUL_P_W-1:bcse_pkg::MUL_B_W]} +
                (b_q[0] ? {1'b0, a_q} : '0);

  // Capture operands, then shift the partial product right one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      steps <= '0;
    end else begin
      if (start) begin
        a_q       <= a;
        b_q       <= b;
        product   <= '0;
        steps     <= bcse_pkg::MUL_CNT_W'(bcse_pkg::MUL_B_W);
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
      end else if (stat.busy) begin
        product   <= {part, product[bcse_pkg::MUL_B_W-1:1]};
        b_q       <= b_q >> 1;
        steps     <= steps - 1'b1;
        stat.busy <= (steps != bcse_pkg::MUL_CNT_W'(1));
        stat.done <= (steps == bcse_pkg::MUL_CNT_W'(1));
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/bcse_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module bcse_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bcse_pkg::DIV_W-1:0]  dividend,
  input  logic [bcse_pkg::DSR_W-1:0]  divisor,
  output logic [bcse_pkg::DIV_W-1:0]  quotient,
  output bcse_pkg::unit_stat_t        stat
);

  logic [bcse_pkg::DSR_W-1:0]     divisor_q;
  logic [bcse_pkg::DSR_W-1:0]     rem;
  logic [bcse_pkg::DIV_CNT_W-1:0] steps;
  logic [bcse_pkg::DSR_W+1:0]     diff;

  // Trial subtract of the divisor from the remainder with the next dividend bit
  assign diff = {1'b0, rem, quotient[bcse_pkg::DIV_W-1]} - {2'b00, divisor_q};

  // Dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      steps <= '0;
    end else begin
      if (start) begin
        quotient  <= dividend;
        divisor_q <= divisor;
        rem       <= '0;
        steps     <= bcse_pkg::DIV_CNT_W'(bcse_pkg::DIV_W);
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
      end else if (stat.busy) begin
        if (!diff[bcse_pkg::DSR_W+1]) begin
          rem <= diff[bcse_pkg::DSR_W-1:0];
        end else begin
          rem <= {rem[bcse_pkg::DSR_W-2:0], quotient[bcse_pkg::DIV_W-1]};
        end
        quotient  <= {quotient[bcse_pkg::DIV_W-2:0], !diff[bcse_pkg::DSR_W+1]};
        steps     <= steps - 1'b1;
        stat.busy <= (steps != bcse_pkg::DIV_CNT_W'(1));
        stat.done <= (steps == bcse_pkg::DIV_CNT_W'(1));
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/bcse_window.sv -----
// Percentage window: a shift line that rotates once per tick to sum its nonzero entries.
module bcse_window #(
  parameter  int WINDOW_LEN = 20,
  localparam int SUM_W      = $clog2(WINDOW_LEN * 127 + 1),
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bcse_pkg::PCT_W-1:0]  pct,
  output logic [SUM_W-1:0]            sum,
  output logic [CNT_W-1:0]            cnt,
  output bcse_pkg::unit_stat_t        stat
);

  logic [bcse_pkg::PCT_W-1:0] entry [WINDOW_LEN];
  logic [CNT_W-1:0]           steps;

  // Drop the oldest word and append the new one, then rotate the full length
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        entry[i] <= '0;
      end
      sum   <= '0;
      cnt   <= '0;
      steps <= '0;
      stat  <= '0;
    end else begin
      if (start) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          entry[i] <= entry[i+1];
        end
        entry[WINDOW_LEN-1] <= pct;
        sum       <= '0;
        cnt       <= '0;
        steps     <= CNT_W'(WINDOW_LEN);
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
      end else if (stat.busy) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          entry[i] <= entry[i+1];
        end
        entry[WINDOW_LEN-1] <= entry[0];
        if (entry[0] != '0) begin
          sum <= sum + SUM_W'(entry[0]);
          cnt <= cnt + 1'b1;
        end
        steps     <= steps - 1'b1;
        stat.busy <= (steps != CNT_W'(1));
        stat.done <= (steps == CNT_W'(1));
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/battery_charge_state_estimator_unit.sv -----
// Battery charge state estimator: coulomb counting with a voltage-average fallback.
//
// One item is worked on at a time. A tick runs the percentage window and then a sequence
// on one bit-serial multiplier (16 steps a product) and one bit-serial divider (40 steps
// a quotient); a discharging tick also works out the open-circuit voltage and, with
// counting enabled, the energy drawn. Skipped ticks, deinit and init with a usable seed
// go straight to the done state; init from the voltage average runs one division and
// one multiplication. The finished result waits in an output register, and the next
// word is taken as soon as the sequencer is back in idle. Configuration writes are
// always accepted and take effect on the next cycle.
module battery_charge_state_estimator_unit #(
  parameter int WINDOW_LEN = 20
) (
  input  logic          clk,
  input  logic          rst,
  bcse_item_if.sink     item,
  bcse_result_if.source result,
  bcse_cfg_if.sink      cfg
);

  localparam int SUM_W = $clog2(WINDOW_LEN * 127 + 1);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  bcse_pkg::state_t state, state_next;
  logic             entry;

  // Estimator state and configuration
  logic [bcse_pkg::WORD_W-1:0] energy;
  logic                        counting;
  logic [bcse_pkg::PCT_W-1:0]  volt_pct;
  logic [bcse_pkg::PCT_W-1:0]  charge_pct;
  logic [bcse_pkg::PCT_W-1:0]  level;
  logic [bcse_pkg::WORD_W-1:0] full_charge;
  logic [bcse_pkg::GAP_W-1:0]  max_gap;

  // Per-item working registers
  bcse_pkg::item_t             item_q;
  logic [bcse_pkg::DIV_W-1:0]  work;
  logic [bcse_pkg::MV_W-1:0]   res_ocv;
  logic                        res_skip;
  logic                        out_valid;
  bcse_pkg::result_t           out_data;

  // Serial units
  logic                         mul_start, div_start, win_start;
  logic [bcse_pkg::MUL_A_W-1:0] mul_a;
  logic [bcse_pkg::MUL_B_W-1:0] mul_b;
  logic [bcse_pkg::MUL_P_W-1:0] mul_prod;
  bcse_pkg::unit_stat_t         mul_stat;
  logic [bcse_pkg::DIV_W-1:0]   div_dvd;
  logic [bcse_pkg::DSR_W-1:0]   div_dsr;
  logic [bcse_pkg::DIV_W-1:0]   div_quot;
  bcse_pkg::unit_stat_t         div_stat;
  logic [SUM_W-1:0]             win_sum;
  logic [CNT_W-1:0]             win_cnt;
  bcse_pkg::unit_stat_t         win_stat;

  logic item_acc;
  logic tick_skip;
  logic seed_fallback;

  assign item.ready    = (state == bcse_pkg::S_IDLE);
  assign item_acc      = item.valid && item.ready;
  assign tick_skip     = counting && (item.data.elapsed_ms > max_gap);
  assign seed_fallback = (item.data.seed_mws == '0) || (item.data.seed_mws > full_charge);

  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Launch a unit on the first cycle of the state that uses it
  assign win_start = entry && (state == bcse_pkg::S_WIN);
  assign mul_start = entry && (state inside {bcse_pkg::S_OCV_MUL, bcse_pkg::S_C1_MUL,
                                             bcse_pkg::S_C2_MUL, bcse_pkg::S_PCT_MUL,
                                             bcse_pkg::S_SEED_MUL});
  assign div_start = entry && (state inside {bcse_pkg::S_C1_DIV, bcse_pkg::S_C2_DIV,
                                             bcse_pkg::S_PCT_DIV, bcse_pkg::S_AVG_DIV,
                                             bcse_pkg::S_SEED_DIV});

  bcse_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
    .clk   (clk),
    .rst   (rst),
    .start (win_start),
    .pct   (item_q.ocv_percent),
    .sum   (win_sum),
    .cnt   (win_cnt),
    .stat  (win_stat)
  );

  bcse_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_prod),
    .stat    (mul_stat)
  );

  bcse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // Hold the sequencer state and mark the first cycle of each state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcse_pkg::S_IDLE;
      entry <= 1'b0;
    end else begin
      state <= state_next;
      entry <= (state_next != state);
    end
  end

  // Next state and unit operands
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_dvd    = '0;
    div_dsr    = '0;
    case (state)
      bcse_pkg::S_IDLE: begin
        if (item_acc) begin
          case (item.data.opcode)
            bcse_pkg::OP_TICK: state_next = tick_skip ? bcse_pkg::S_DONE : bcse_pkg::S_WIN;
            bcse_pkg::OP_INIT: state_next = seed_fallback ? bcse_pkg::S_SEED_DIV
                                                          : bcse_pkg::S_DONE;
            default:           state_next = bcse_pkg::S_DONE;
          endcase
        end
      end
      bcse_pkg::S_WIN: begin
        if (win_stat.done) begin
          state_next = item_q.charger_present ? bcse_pkg::S_PCT_CHK : bcse_pkg::S_OCV_MUL;
        end
      end
      bcse_pkg::S_OCV_MUL: begin
        mul_a = bcse_pkg::RECIP_TEN;
        mul_b = item_q.system_ma;
        if (mul_stat.done) begin
          state_next = counting ? bcse_pkg::S_C1_MUL : bcse_pkg::S_PCT_CHK;
        end
      end
      bcse_pkg::S_C1_MUL: begin
        mul_a = bcse_pkg::MUL_A_W'(res_ocv);
        mul_b = item_q.system_ma;
        if (mul_stat.done) state_next = bcse_pkg::S_C1_DIV;
      end
      bcse_pkg::S_C1_DIV: begin
        div_dvd = work;
        div_dsr = bcse_pkg::MS_PER_S;
        if (div_stat.done) state_next = bcse_pkg::S_C2_MUL;
      end
      bcse_pkg::S_C2_MUL: begin
        mul_a = work[bcse_pkg::MUL_A_W-1:0];
        mul_b = item_q.elapsed_ms;
        if (mul_stat.done) state_next = bcse_pkg::S_C2_DIV;
      end
      bcse_pkg::S_C2_DIV: begin
        div_dvd = work;
        div_dsr = bcse_pkg::MS_PER_S;
        if (div_stat.done) state_next = bcse_pkg::S_PCT_CHK;
      end
      bcse_pkg::S_PCT_CHK: begin
        if (counting && (full_charge != '0) && (energy <= full_charge)) begin
          state_next = bcse_pkg::S_PCT_MUL;
        end else begin
          state_next = bcse_pkg::S_AVG_CHK;
        end
      end
      bcse_pkg::S_PCT_MUL: begin
        mul_a = energy;
        mul_b = bcse_pkg::MUL_B_W'(bcse_pkg::PCT_FULL);
        if (mul_stat.done) state_next = bcse_pkg::S_PCT_DIV;
      end
      bcse_pkg::S_PCT_DIV: begin
        div_dvd = work;
        div_dsr = full_charge;
        if (div_stat.done) state_next = bcse_pkg::S_AVG_CHK;
      end
      bcse_pkg::S_AVG_CHK: begin
        state_next = (win_cnt != '0) ? bcse_pkg::S_AVG_DIV : bcse_pkg::S_LEVEL;
      end
      bcse_pkg::S_AVG_DIV: begin
        div_dvd = bcse_pkg::DIV_W'(win_sum);
        div_dsr = bcse_pkg::DSR_W'(win_cnt);
        if (div_stat.done) state_next = bcse_pkg::S_LEVEL;
      end
      bcse_pkg::S_LEVEL: begin
        state_next = bcse_pkg::S_DONE;
      end
      bcse_pkg::S_SEED_DIV: begin
        div_dvd = bcse_pkg::DIV_W'(full_charge);
        div_dsr = bcse_pkg::DSR_W'(bcse_pkg::PCT_FULL);
        if (div_stat.done) state_next = bcse_pkg::S_SEED_MUL;
      end
      bcse_pkg::S_SEED_MUL: begin
        mul_a = work[bcse_pkg::MUL_A_W-1:0];
        mul_b = bcse_pkg::MUL_B_W'(volt_pct);
        if (mul_stat.done) state_next = bcse_pkg::S_DONE;
      end
      bcse_pkg::S_DONE: begin
        if (!out_valid || result.ready) state_next = bcse_pkg::S_IDLE;
      end
      default: begin
        state_next = bcse_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      full_charge <= bcse_pkg::FULL_CHARGE_RESET;
      max_gap     <= bcse_pkg::MAX_GAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.index)
        bcse_pkg::REG_FULL_CHARGE: full_charge <= cfg.data.value;
        bcse_pkg::REG_MAX_GAP:     max_gap     <= cfg.data.value[bcse_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Item working registers
  always_ff @(posedge clk) begin
    if (item_acc) begin
      item_q   <= item.data;
      res_ocv  <= (item.data.opcode == bcse_pkg::OP_TICK && !tick_skip) ?
                  item.data.battery_mv : '0;
      res_skip <= (item.data.opcode == bcse_pkg::OP_TICK) && tick_skip;
    end
    if (state == bcse_pkg::S_OCV_MUL && mul_stat.done) begin
      res_ocv <= item_q.battery_mv + mul_prod[bcse_pkg::RECIP_SHIFT +: bcse_pkg::MV_W];
    end
    if (mul_stat.done) work <= mul_prod[bcse_pkg::DIV_W-1:0];
    if (div_stat.done) work <= div_quot;
  end

  // Estimator state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      energy     <= '0;
      counting   <= 1'b0;
      volt_pct   <= '0;
      charge_pct <= '0;
      level      <= '0;
    end else begin
      case (state)
        bcse_pkg::S_IDLE: begin
          if (item_acc) begin
            case (item.data.opcode)
              bcse_pkg::OP_INIT: begin
                counting <= 1'b1;
                if (!seed_fallback) energy <= item.data.seed_mws;
              end
              bcse_pkg::OP_DEINIT: counting <= 1'b0;
              default: ;
            endcase
          end
        end
        bcse_pkg::S_C2_DIV: begin
          if (div_stat.done) begin
            if (bcse_pkg::DIV_W'(energy) > div_quot) begin
              energy <= energy - div_quot[bcse_pkg::WORD_W-1:0];
            end else begin
              energy <= '0;
            end
          end
        end
        bcse_pkg::S_PCT_DIV: begin
          if (div_stat.done) charge_pct <= div_quot[bcse_pkg::PCT_W-1:0];
        end
        bcse_pkg::S_AVG_CHK: begin
          if (win_cnt == '0) volt_pct <= '0;
        end
        bcse_pkg::S_AVG_DIV: begin
          if (div_stat.done) volt_pct <= div_quot[bcse_pkg::PCT_W-1:0];
        end
        bcse_pkg::S_LEVEL: begin
          if (counting) begin
            if (charge_pct inside {[7'd1:bcse_pkg::PCT_FULL]}) level <= charge_pct;
          end else begin
            if (volt_pct inside {[7'd1:bcse_pkg::PCT_FULL]}) level <= volt_pct;
          end
        end
        bcse_pkg::S_SEED_MUL: begin
          if (mul_stat.done) begin
            if (|mul_prod[bcse_pkg::MUL_P_W-1:bcse_pkg::WORD_W]) begin
              energy <= '1;
            end else begin
              energy <= mul_prod[bcse_pkg::WORD_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: drop the word once taken, load a new one when done
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == bcse_pkg::S_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bcse_pkg::S_DONE && (!out_valid || result.ready)) begin
      out_data.battery_level   <= level;
      out_data.voltage_percent <= volt_pct;
      out_data.charge_percent  <= charge_pct;
      out_data.open_circuit_mv <= res_ocv;
      out_data.skipped         <= res_skip;
    end
  end

`ifndef SYNTHESIS
  // The shared multiplier and divider never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // A tick only ever drains the energy count
  a_tick_drains: assert property (@(posedge clk) disable iff (rst)
    (state != bcse_pkg::S_IDLE && item_q.opcode == bcse_pkg::OP_TICK)
    |=> (energy <= $past(energy)))
    else $error("energy count rose during a tick");

  // A fresh charge percentage is never above full
  a_charge_bounded: assert property (@(posedge clk) disable iff (rst)
    (charge_pct != $past(charge_pct)) |-> (charge_pct <= bcse_pkg::PCT_FULL))
    else $error("charge percentage above full");

  // A result word appears only from the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == bcse_pkg::S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
